[rtl/pebr_pkg.sv]
// Package with the types, constants and codes of the base-relocation fixup block.
`default_nettype none
package pebr_pkg;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned EntryWidth = 16;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned TypeShift  = 12;
  localparam int unsigned HalfWidth  = 16;

  localparam logic [11:0] OfsMask    = 12'hfff;
  localparam logic [31:0] RoundHalf  = 32'h0000_8000;
  localparam logic [25:0] JmpMask    = 26'h3ff_ffff;
  localparam logic [11:0] FinalFlag  = 12'h002;

  typedef enum logic [3:0] {
    REL_ABSOLUTE     = 4'd0,
    REL_HIGH         = 4'd1,
    REL_LOW          = 4'd2,
    REL_HIGHLOW      = 4'd3,
    REL_HIGHADJ      = 4'd4,
    REL_MIPS_JMPADDR = 4'd5,
    REL_DIR64        = 4'd10
  } rel_type_t;

  typedef enum logic [1:0] {
    WIDTH_NONE  = 2'd0,
    WIDTH_TWO   = 2'd1,
    WIDTH_FOUR  = 2'd2,
    WIDTH_EIGHT = 2'd3
  } write_width_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PAIR = 2'd1,
    KIND_SKIP = 2'd2,
    KIND_IDLE = 2'd3
  } pending_kind_t;

  typedef struct packed {
    pending_kind_t          kind;
    logic [HalfWidth-1:0]   held_high_half;
    logic [AddrWidth-1:0]   held_target;
  } pebr_state_t;

  typedef struct packed {
    logic [AddrWidth-1:0]   target_address;
    logic [ValueWidth-1:0]  new_value;
    write_width_t           write_width;
    logic                   error;
  } pebr_result_t;

endpackage
`default_nettype wire

[rtl/pe_base_relocation_fixup.sv]
// Top level of the PE base-relocation fixup block.
//
// The block takes one relocation entry per cycle; its result comes from an output
// register in the cycle after acceptance; a full output register that is stalled
// stops input acceptance. A HIGHADJ entry that opens a pair gives no result itself;
// the pair's result appears with the following entry. The delta register is written
// through the configuration channel, which is always ready, and must only change
// while idle.
`default_nettype none
module pe_base_relocation_fixup (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pebr_pkg::ValueWidth-1:0] delta,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [pebr_pkg::AddrWidth-1:0]  page_address,
  input  wire logic [pebr_pkg::EntryWidth-1:0] entry,
  input  wire logic [pebr_pkg::ValueWidth-1:0] target_value,
  input  wire logic                            block_last,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [pebr_pkg::AddrWidth-1:0]       target_address,
  output logic [pebr_pkg::ValueWidth-1:0]      new_value,
  output logic [1:0]                           write_width,
  output logic                                 error
);
  import pebr_pkg::*;

  logic [ValueWidth-1:0] delta_value;
  pebr_state_t           state;
  pebr_state_t           state_next;
  pebr_result_t          result;
  pebr_result_t          result_next;
  logic                  has_result;
  logic                  in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  pebr_fixup u_fixup (
    .page_address (page_address),
    .entry        (entry),
    .target_value (target_value),
    .block_last   (block_last),
    .delta        (delta_value),
    .state        (state),
    .state_next   (state_next),
    .result       (result_next),
    .has_result   (has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_value <= '0;
      state       <= '{kind: KIND_NONE, held_high_half: '0, held_target: '0};
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delta_value <= delta;
      end
      if (in_accept) begin
        state     <= state_next;
        out_valid <= has_result;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && has_result) begin
      result <= result_next;
    end
  end

  assign target_address = result.target_address;
  assign new_value      = result.new_value;
  assign write_width    = result.write_width;
  assign error          = result.error;

endmodule
`default_nettype wire

[rtl/pebr_fixup.sv]
// Combinational fixup of one relocation entry, including the HIGHADJ pairing state.
`default_nettype none
module pebr_fixup (
  input  wire logic [pebr_pkg::AddrWidth-1:0]  page_address,
  input  wire logic [pebr_pkg::EntryWidth-1:0] entry,
  input  wire logic [pebr_pkg::ValueWidth-1:0] target_value,
  input  wire logic                            block_last,
  input  wire logic [pebr_pkg::ValueWidth-1:0] delta,
  input  wire pebr_pkg::pebr_state_t           state,
  output pebr_pkg::pebr_state_t                state_next,
  output pebr_pkg::pebr_result_t               result,
  output logic                                 has_result
);
  import pebr_pkg::*;

  logic [11:0]          ofs;
  logic [3:0]           type_code;
  logic [AddrWidth-1:0] addr;
  logic [31:0]          d32;
  logic [31:0]          lo_ext;
  logic [31:0]          pair_sum;
  logic [31:0]          high_sum;
  logic [31:0]          low_sum;
  logic [31:0]          hl_sum;
  logic [31:0]          jmp_sum;
  logic [63:0]          dir_sum;

  assign ofs       = entry[11:0] & OfsMask;
  assign type_code = entry[EntryWidth-1:TypeShift];
  assign addr      = page_address + {20'd0, ofs};
  assign d32       = delta[31:0];
  assign lo_ext    = {{16{entry[15]}}, entry};
  assign pair_sum  = {state.held_high_half, 16'd0} + lo_ext + d32 + RoundHalf;
  assign high_sum  = {target_value[15:0], 16'd0} + d32;
  assign low_sum   = {16'd0, target_value[15:0]} + d32;
  assign hl_sum    = target_value[31:0] + d32;
  assign jmp_sum   = {target_value[25:0] & JmpMask, 2'b00} + d32;
  assign dir_sum   = target_value + delta;

  always_comb begin
    state_next            = state;
    state_next.kind       = KIND_NONE;
    has_result            = 1'b1;
    result.target_address = addr;
    result.new_value      = '0;
    result.write_width    = WIDTH_NONE;
    result.error          = 1'b0;
    priority if (state.kind == KIND_PAIR) begin
      result.target_address = state.held_target;
      result.new_value      = {48'd0, pair_sum[31:16]};
      result.write_width    = WIDTH_TWO;
    end else if (state.kind == KIND_SKIP) begin
      has_result = 1'b0;
    end else begin
      unique case (type_code)
        REL_ABSOLUTE: begin
        end
        REL_HIGH: begin
          result.new_value   = {48'd0, high_sum[31:16]};
          result.write_width = WIDTH_TWO;
        end
        REL_LOW: begin
          result.new_value   = {48'd0, low_sum[15:0]};
          result.write_width = WIDTH_TWO;
        end
        REL_HIGHLOW: begin
          result.new_value   = {32'd0, hl_sum};
          result.write_width = WIDTH_FOUR;
        end
        REL_HIGHADJ: begin
          priority if (block_last) begin
            result.error = 1'b1;
          end else if ((ofs & FinalFlag) != 12'd0) begin
            state_next.kind = KIND_SKIP;
          end else begin
            state_next.kind           = KIND_PAIR;
            state_next.held_high_half = target_value[15:0];
            state_next.held_target    = addr;
            has_result                = 1'b0;
          end
        end
        REL_MIPS_JMPADDR: begin
          result.new_value   = {32'd0, target_value[31:26], jmp_sum[27:2] & JmpMask};
          result.write_width = WIDTH_FOUR;
        end
        REL_DIR64: begin
          result.new_value   = dir_sum;
          result.write_width = WIDTH_EIGHT;
        end
        default: begin
          result.error = 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[verif/reloc_fixup_scoreboard_pkg.sv]
// Scoreboard class that predicts and checks the base-relocation fixup results.
package reloc_fixup_scoreboard_pkg;
  import pebr_pkg::*;

  class reloc_fixup_scoreboard;
    logic [ValueWidth-1:0] image_delta = '0;
    pending_kind_t kind = KIND_NONE;
    logic [HalfWidth-1:0] held_high_half = '0;
    logic [AddrWidth-1:0] held_target = '0;
    pebr_result_t expected_fixups[$];
    int unsigned failures = 0;

    function void note_entry(logic [AddrWidth-1:0] page, logic [EntryWidth-1:0] ent,
                             logic [ValueWidth-1:0] tv, logic last);
      logic [11:0] ofs;
      logic [3:0] reloc_code;
      logic [31:0] d32;
      logic [31:0] sum;
      logic [31:0] word;
      pebr_result_t fix;
      ofs = ent[11:0];
      reloc_code = ent[15:TypeShift];
      d32 = image_delta[31:0];
      fix.target_address = page + {20'h0, ofs};
      fix.new_value = '0;
      fix.write_width = WIDTH_NONE;
      fix.error = 1'b0;
      if (kind == KIND_PAIR) begin
        // The entry after a HIGHADJ is the signed low half of the adjusted value.
        sum = {held_high_half, 16'h0} + {{16{ent[15]}}, ent} + d32 + RoundHalf;
        kind = KIND_NONE;
        fix.target_address = held_target;
        fix.new_value = {48'h0, sum[31:16]};
        fix.write_width = WIDTH_TWO;
        expected_fixups.push_back(fix);
        return;
      end
      if (kind == KIND_SKIP) begin
        kind = KIND_NONE;
        return;
      end
      kind = KIND_NONE;
      case (reloc_code)
        REL_ABSOLUTE: ;
        REL_HIGH: begin
          sum = {tv[15:0], 16'h0} + d32;
          fix.new_value = {48'h0, sum[31:16]};
          fix.write_width = WIDTH_TWO;
        end
        REL_LOW: begin
          sum = {16'h0, tv[15:0]} + d32;
          fix.new_value = {48'h0, sum[15:0]};
          fix.write_width = WIDTH_TWO;
        end
        REL_HIGHLOW: begin
          sum = tv[31:0] + d32;
          fix.new_value = {32'h0, sum};
          fix.write_width = WIDTH_FOUR;
        end
        REL_HIGHADJ: begin
          if (last) begin
            fix.error = 1'b1;
          end else if ((ofs & FinalFlag) != '0) begin
            kind = KIND_SKIP;
          end else begin
            kind = KIND_PAIR;
            held_high_half = tv[15:0];
            held_target = fix.target_address;
            return;
          end
        end
        REL_MIPS_JMPADDR: begin
          word = tv[31:0];
          sum = {word[25:0], 2'b00} + d32;
          fix.new_value = {32'h0, word[31:26], sum[27:2]};
          fix.write_width = WIDTH_FOUR;
        end
        REL_DIR64: begin
          fix.new_value = tv + image_delta;
          fix.write_width = WIDTH_EIGHT;
        end
        default: fix.error = 1'b1;
      endcase
      expected_fixups.push_back(fix);
    endfunction

    function void check_result(logic [AddrWidth-1:0] addr, logic [ValueWidth-1:0] value,
                               logic [1:0] width, logic err);
      pebr_result_t want;
      if (expected_fixups.size() == 0) begin
        if (failures < 10) begin
          $display("%0t: unexpected result transaction: addr %h value %h width %0d error %0b",
                   $time, addr, value, width, err);
        end
        failures++;
        return;
      end
      want = expected_fixups.pop_front();
      if (addr !== want.target_address || value !== want.new_value ||
          width !== want.write_width || err !== want.error) begin
        if (failures < 10) begin
          $display("%0t: result mismatch: expected addr %h value %h width %0d error %0b",
                   $time, want.target_address, want.new_value, want.write_width, want.error);
          $display("%0t:                  got      addr %h value %h width %0d error %0b",
                   $time, addr, value, width, err);
        end
        failures++;
      end
    endfunction
  endclass

endpackage

[verif/tb_pe_base_relocation_fixup.sv]
// Testbench top that drives the relocation fixup block with random traffic and checks it.
module tb_pe_base_relocation_fixup;
  timeunit 1ns;
  timeprecision 1ps;
  import pebr_pkg::*;
  import reloc_fixup_scoreboard_pkg::*;

  localparam int unsigned ResetCycles = 12;
  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 6;
  localparam longint unsigned LimitNs = 1_000_000;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ValueWidth-1:0] new_delta = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [AddrWidth-1:0] page_address = '0;
  logic [EntryWidth-1:0] entry = '0;
  logic [ValueWidth-1:0] target_value = '0;
  logic block_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AddrWidth-1:0] target_address;
  logic [ValueWidth-1:0] new_value;
  logic [1:0] write_width;
  logic error;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int unsigned entries_sent = 0;
  reloc_fixup_scoreboard sb = new;

  pe_base_relocation_fixup DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .delta          (new_delta),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .page_address   (page_address),
    .entry          (entry),
    .target_value   (target_value),
    .block_last     (block_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .target_address (target_address),
    .new_value      (new_value),
    .write_width    (write_width),
    .error          (error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LimitNs);
    $display("tb_pe_base_relocation_fixup: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.image_delta = new_delta;
      if (in_valid && !in_stall) sb.note_entry(page_address, entry, target_value, block_last);
      if (out_valid && !out_stall) sb.check_result(target_address, new_value, write_width, error);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] pick_code();
    logic [3:0] code;
    if ($urandom_range(0, 9) == 0) begin
      code = 4'($urandom_range(REL_MIPS_JMPADDR + 1, 15));
      if (code == REL_DIR64) code = 4'(REL_DIR64 + 1);
    end else begin
      case ($urandom_range(0, 8))
        0: code = REL_ABSOLUTE;
        1: code = REL_HIGH;
        2: code = REL_LOW;
        3: code = REL_HIGHLOW;
        4, 5: code = REL_HIGHADJ;
        6: code = REL_MIPS_JMPADDR;
        default: code = REL_DIR64;
      endcase
    end
    return code;
  endfunction

  // The receiver stalls at random and holds off for a long stretch on request.
  initial begin
    int unsigned n;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
        n = 0;
      end else begin
        n = pick_gap();
      end
      out_stall <= (n != 0);
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_entry(input logic [AddrWidth-1:0] page, input logic [EntryWidth-1:0] ent,
                            input logic [ValueWidth-1:0] tv, input logic last);
    in_valid <= 1'b1;
    page_address <= page;
    entry <= ent;
    target_value <= tv;
    block_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    entries_sent++;
  endtask

  task automatic offer(input logic [AddrWidth-1:0] page, input logic [EntryWidth-1:0] ent,
                       input logic [ValueWidth-1:0] tv, input logic last);
    int unsigned n;
    send_entry(page, ent, tv, last);
    n = pick_gap();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // A HIGHADJ that is still open is closed with a filler entry so that the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    if (sb.kind == KIND_PAIR || sb.kind == KIND_SKIP) begin
      send_entry('0, {REL_ABSOLUTE, 12'h000}, '0, 1'b1);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.expected_fixups.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_delta(input logic [ValueWidth-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    new_delta <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic offer_block();
    logic [AddrWidth-1:0] page;
    logic [3:0] code;
    logic [11:0] ofs;
    int unsigned len;
    int unsigned i;
    page = $urandom;
    if ($urandom_range(0, 7) != 0) page[11:0] = '0;
    len = $urandom_range(1, 12);
    if (!hold_req) calm = ($urandom_range(0, 7) == 0);
    i = 0;
    while (i < len) begin
      code = pick_code();
      if (code == REL_HIGHADJ && i == len - 1 && $urandom_range(0, 3) != 0) code = REL_HIGHLOW;
      ofs = 12'($urandom_range(0, 4095));
      offer(page, {code, ofs}, {$urandom, $urandom}, i == len - 1);
      i++;
      if (code == REL_HIGHADJ && i < len && !ofs[1]) begin
        offer(page, 16'($urandom_range(0, 65535)), {$urandom, $urandom}, i == len - 1);
        i++;
      end
    end
  endtask

  initial begin
    logic [ValueWidth-1:0] delta_plan [7];
    int unsigned phase_start;
    bit pressed;
    pressed = 1'b0;
    delta_plan = '{64'h0000_0000_0000_0001, 64'hffff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
                   64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h0000_0000_ffff_8000,
                   {$urandom, $urandom}};
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_delta(64'hffff_ffff_0001_8000);
    offer(32'h0000_0000, {REL_ABSOLUTE, 12'h000}, '1, 1'b0);
    offer(32'hffff_ffff, {REL_ABSOLUTE, 12'hfff}, '0, 1'b1);
    offer(32'h1234_5000, {REL_HIGH, 12'habc}, '1, 1'b0);
    offer(32'h0040_1000, {REL_LOW, 12'h001}, 64'h0000_0000_0000_ffff, 1'b0);
    offer(32'h8000_0000, {REL_HIGHLOW, 12'hffe}, 64'h0000_0000_ffff_ffff, 1'b0);
    offer(32'h7fff_f000, {REL_DIR64, 12'h123}, '1, 1'b0);
    offer(32'h0001_0000, {REL_MIPS_JMPADDR, 12'h010}, '1, 1'b1);
    offer(32'h0002_0000, {REL_HIGHADJ, 12'h100}, 64'h0000_0000_0000_1234, 1'b0);
    offer(32'h0002_0000, 16'h8000, '0, 1'b1);
    offer(32'h0003_0000, {REL_HIGHADJ, 12'h104}, 64'h0000_0000_0000_ffff, 1'b0);
    offer(32'h0003_0000, {REL_HIGHADJ, 12'hffd}, '0, 1'b0);
    offer(32'h0004_0000, {REL_HIGHADJ, 12'h002}, '0, 1'b0);
    offer(32'h0004_0000, {REL_HIGHLOW, 12'h008}, '1, 1'b1);
    offer(32'h0005_0000, {REL_HIGHADJ, 12'h000}, '1, 1'b1);
    offer(32'h0006_0000, {REL_HIGHADJ, 12'h002}, '0, 1'b1);
    for (int c = 0; c < 16; c++) begin
      if (c > REL_MIPS_JMPADDR && c != REL_DIR64) begin
        offer(32'h0007_0000, {4'(c), 12'h0f0}, '1, 1'b0);
      end
    end

    for (int p = 0; p < 7; p++) begin
      load_delta(delta_plan[p]);
      phase_start = entries_sent;
      while (entries_sent - phase_start < ItemsPerPhase) begin
        if (p == 2 && !pressed && entries_sent - phase_start >= 80) begin
          hold_req = 1'b1;
          calm = 1'b1;
          pressed = 1'b1;
        end
        offer_block();
      end
    end

    settle();
    if (sb.failures == 0 && sb.expected_fixups.size() == 0) begin
      $display("tb_pe_base_relocation_fixup: done, clean");
    end else begin
      $display("tb_pe_base_relocation_fixup: done, errors");
    end
    $finish;
  end

endmodule
